/* hdl/ksc_pkg.sv */
// Shared types and constants for the keyword substitution cipher.
package ksc_pkg;

    localparam int ALPHA_SIZE = 26;
    localparam int LETTER_W   = $clog2(ALPHA_SIZE);
    localparam int CHAR_W     = 8;
    localparam int CMD_W      = 2;

    localparam logic [CHAR_W-1:0] LETTER_BASE = 8'h61;
    localparam logic [CHAR_W-1:0] LETTER_END  = 8'h7b;
    localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(ALPHA_SIZE - 1);
    localparam logic [LETTER_W-1:0] KEY_FULL    = LETTER_W'(ALPHA_SIZE);

    typedef enum logic [CMD_W-1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_TEXT   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_KEY,
        ST_FILL
    } t_state;

endpackage

/* hdl/ksc_ram.sv */
// Generic simple dual-port RAM with registered read.
module ksc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/keyword_substitution_cipher.sv */
// Keyword substitution cipher: key capture, map build and byte substitution.
//
//  channel  | signals                        | handshake
//  ---------+--------------------------------+-------------------------------
//  command  | i_cmd, i_char_in               | start high, busy low
//  result   | o_char_out                     | o_strobe, one cycle, no stall
//
//  Clear, add-key and text beats may follow back to back; a text result
//  appears in the cycle after its beat (map RAM read).
//  Finish holds busy for one pass over the key RAM, each letter read being
//  written to the map in key order, plus a drain and an exit step, then one
//  pass over the alphabet from the last letter down, writing each unused one.
//  Reset empties the key; the map reads as identity until the first finish.
//  Results cannot be stalled by the receiver.
module keyword_substitution_cipher
    import ksc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [CHAR_W-1:0] i_char_in,
    output logic              o_strobe,
    output logic [CHAR_W-1:0] o_char_out
);

    t_state r_state, n_state;

    logic [ALPHA_SIZE-1:0] r_used, n_used;
    logic [LETTER_W-1:0]   r_key_cnt, n_key_cnt;
    logic [ALPHA_SIZE-1:0] r_map_vld, n_map_vld;
    logic [LETTER_W-1:0]   r_rd_idx, n_rd_idx;
    logic                  r_rd_pend, n_rd_pend;
    logic [LETTER_W-1:0]   r_pos, n_pos;
    logic [LETTER_W-1:0]   r_letter, n_letter;

    logic                  r_out_vld;
    logic                  r_out_lower;
    logic                  r_out_mvld;
    logic [CHAR_W-1:0]     r_out_ch;

    logic                  w_accept;
    t_cmd                  w_cmd;
    logic                  w_lower;
    logic [CHAR_W-1:0]     w_diff;
    logic [LETTER_W-1:0]   w_idx;

    logic                  w_key_we;
    logic                  w_key_re;
    logic [LETTER_W-1:0]   w_key_rdata;
    logic                  w_map_we;
    logic [LETTER_W-1:0]   w_map_wdata;
    logic                  w_map_re;
    logic [LETTER_W-1:0]   w_map_rdata;

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_cmd    = t_cmd'(i_cmd);
    assign w_lower  = (i_char_in >= LETTER_BASE) && (i_char_in < LETTER_END);
    assign w_diff   = i_char_in - LETTER_BASE;
    assign w_idx    = w_diff[LETTER_W-1:0];

    ksc_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (ALPHA_SIZE)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (w_key_we),
        .i_waddr (r_key_cnt),
        .i_wdata (w_idx),
        .i_re    (w_key_re),
        .i_raddr (r_rd_idx),
        .o_rdata (w_key_rdata)
    );

    ksc_ram #(
        .WIDTH (LETTER_W),
        .DEPTH (ALPHA_SIZE)
    ) u_map_ram (
        .i_clk   (i_clk),
        .i_we    (w_map_we),
        .i_waddr (r_pos),
        .i_wdata (w_map_wdata),
        .i_re    (w_map_re),
        .i_raddr (w_idx),
        .o_rdata (w_map_rdata)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept && w_cmd == CMD_FINISH) begin
                    n_state = ST_KEY;
                end
            end
            ST_KEY: begin
                if (r_rd_idx == r_key_cnt && !r_rd_pend) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                if (r_letter == '0) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_used      = r_used;
        n_key_cnt   = r_key_cnt;
        n_map_vld   = r_map_vld;
        n_rd_idx    = r_rd_idx;
        n_rd_pend   = 1'b0;
        n_pos       = r_pos;
        n_letter    = r_letter;
        w_key_we    = 1'b0;
        w_key_re    = 1'b0;
        w_map_we    = 1'b0;
        w_map_wdata = r_letter;
        w_map_re    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_cmd)
                        CMD_CLEAR: begin
                            n_used    = '0;
                            n_key_cnt = '0;
                        end
                        CMD_ADD: begin
                            if (w_lower && !r_used[w_idx] && r_key_cnt < KEY_FULL) begin
                                w_key_we         = 1'b1;
                                n_key_cnt        = r_key_cnt + 1'b1;
                                n_used[w_idx]    = 1'b1;
                            end
                        end
                        CMD_FINISH: begin
                            n_rd_idx = '0;
                            n_pos    = '0;
                            n_letter = LAST_LETTER;
                        end
                        CMD_TEXT: begin
                            w_map_re = w_lower;
                        end
                        default: ;
                    endcase
                end
            end
            ST_KEY: begin
                if (r_rd_idx < r_key_cnt) begin
                    w_key_re  = 1'b1;
                    n_rd_idx  = r_rd_idx + 1'b1;
                    n_rd_pend = 1'b1;
                end
                if (r_rd_pend) begin
                    w_map_we         = 1'b1;
                    w_map_wdata      = w_key_rdata;
                    n_map_vld[r_pos] = 1'b1;
                    n_pos            = r_pos + 1'b1;
                end
            end
            ST_FILL: begin
                if (!r_used[r_letter] && r_pos < KEY_FULL) begin
                    w_map_we         = 1'b1;
                    n_map_vld[r_pos] = 1'b1;
                    n_pos            = r_pos + 1'b1;
                end
                if (r_letter != '0) begin
                    n_letter = r_letter - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_used    <= '0;
            r_key_cnt <= '0;
            r_map_vld <= '0;
            r_rd_pend <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_key_cnt <= n_key_cnt;
            r_map_vld <= n_map_vld;
            r_rd_pend <= n_rd_pend;
            r_out_vld <= w_accept && w_cmd == CMD_TEXT;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        r_pos    <= n_pos;
        r_letter <= n_letter;
        if (w_accept && w_cmd == CMD_TEXT) begin
            r_out_ch    <= i_char_in;
            r_out_lower <= w_lower;
            r_out_mvld  <= w_lower && r_map_vld[w_idx];
        end
    end

    assign o_strobe   = r_out_vld;
    assign o_char_out = (r_out_lower && r_out_mvld)
                      ? CHAR_W'(LETTER_BASE + {{(CHAR_W-LETTER_W){1'b0}}, w_map_rdata})
                      : r_out_ch;

    a_strobe_follows_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy && i_cmd == CMD_TEXT))
        else $error("result strobe without a text beat");

    a_count_matches_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == int'(r_key_cnt))
        else $error("key count out of step with used mask");

    a_map_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> (&r_map_vld && r_pos == KEY_FULL))
        else $error("map build ended with entries unwritten");

    a_key_static_in_build: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy && $past(busy)) |-> ($stable(r_key_cnt) && $stable(r_used)))
        else $error("key changed during map build");

endmodule
